@@ src/pfrq_pkg.sv @@
// Shared types and constants for the preamble frame receiver queue.
// Holds the transfer payload structs, the result codes and the preamble test.
// Depends on nothing; every other file of the block imports it.
package pfrq_pkg;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_DROP    = 2'd2;

   localparam logic [7:0] PRE_A = 8'h7F;
   localparam logic [7:0] PRE_B = 8'hFF;
   localparam int PRE_LEN = 4;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } pfrq_req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic       last_of_run;
   } pfrq_rsp_type;

   typedef struct packed {
      logic store;
      logic done;
   } pfrq_sync_type;

   typedef enum logic {
      ST_IDLE,
      ST_TAKE
   } pfrq_state_type;

   function automatic logic is_preamble(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3);
      return (b0 == PRE_A) && (b1 == PRE_B) && (b2 == PRE_A) && (b3 == PRE_B);
   endfunction

endpackage

@@ src/pfrq_sync.sv @@
// Preamble hunt and frame position tracking for the frame receiver queue.
// Keeps the last four received bytes and tells the top level where to store each byte.
// Depends on pfrq_pkg.
module pfrq_sync #(
   parameter int FRAME_BYTES = 22,
   localparam int OFF_W = $clog2(FRAME_BYTES - pfrq_pkg::PRE_LEN + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_valid,
   input  logic [7:0]              rx_byte,
   output pfrq_pkg::pfrq_sync_type sync,
   output logic [OFF_W-1:0]        offset
);
   import pfrq_pkg::*;

   localparam int POS_W = $clog2(FRAME_BYTES);

   logic [POS_W-1:0] fp_ff, fp_in;
   logic [7:0]       hist_ff [4];
   logic [POS_W:0]   pos_next;
   logic             store;
   logic             done;

   always_comb begin
      pos_next = {1'b0, fp_ff} + (POS_W+1)'(1);
      store    = 1'b0;
      offset   = '0;
      if (fp_ff == POS_W'(PRE_LEN - 1)) begin
         if (!is_preamble(hist_ff[1], hist_ff[2], hist_ff[3], rx_byte)) begin
            pos_next = (POS_W+1)'(PRE_LEN - 1);
         end
      end else if (fp_ff >= POS_W'(PRE_LEN)) begin
         store  = 1'b1;
         offset = OFF_W'(fp_ff - POS_W'(PRE_LEN));
         if (fp_ff > POS_W'(PRE_LEN) &&
             is_preamble(hist_ff[0], hist_ff[1], hist_ff[2], hist_ff[3])) begin
            offset   = '0;
            pos_next = (POS_W+1)'(PRE_LEN + 1);
         end
      end
      done = (pos_next == (POS_W+1)'(FRAME_BYTES));
      fp_in = fp_ff;
      if (byte_valid) begin
         fp_in = done ? '0 : POS_W'(pos_next);
      end
      sync.store = byte_valid & store;
      sync.done  = byte_valid & done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fp_ff <= '0;
      end else begin
         fp_ff <= fp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_valid) begin
         hist_ff[0] <= hist_ff[1];
         hist_ff[1] <= hist_ff[2];
         hist_ff[2] <= hist_ff[3];
         hist_ff[3] <= rx_byte;
      end
   end

endmodule

@@ src/preamble_frame_receiver_queue.sv @@
// Preamble frame receiver queue: top level with the message memory and take sequencer.
// A take of a queued message hands out its FRAME_BYTES - 4 payload bytes one at a time, with
// a single read in flight on the message memory: the next read is issued only once the previous
// byte has been placed in the response register and the response is free to take a new one.
// Reset clears the frame position and ring indices; the memory is not cleared.
module preamble_frame_receiver_queue #(
   parameter int FRAME_BYTES = 22,
   parameter int SLOTS       = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pfrq_pkg::pfrq_req_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pfrq_pkg::pfrq_rsp_type rsp_item
);
   import pfrq_pkg::*;

   localparam int PAY    = FRAME_BYTES - PRE_LEN;
   localparam int OFF_W  = $clog2(PAY + 1);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int DEPTH  = SLOTS * PAY;
   localparam int ADDR_W = $clog2(DEPTH);

   pfrq_state_type    state_ff, state_in;
   logic [SLOT_W-1:0] wslot_ff, wslot_in;
   logic [SLOT_W-1:0] rslot_ff, rslot_in;
   logic [ADDR_W-1:0] rbase_ff, rbase_in;
   logic [OFF_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              inflight_ff, inflight_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pfrq_rsp_type      rsp_ff, rsp_in;
   logic [7:0]        rdata_ff;

   logic [7:0]        store_mem [DEPTH];

   pfrq_sync_type     sync;
   logic [OFF_W-1:0]  offset;
   logic              out_free;
   logic              accept;
   logic              byte_valid;
   logic              empty;
   logic              full;
   logic [SLOT_W-1:0] wnext;
   logic [SLOT_W-1:0] rnext;
   logic [ADDR_W-1:0] waddr;
   logic [ADDR_W-1:0] raddr;
   logic              rd_en;
   logic              last;

   pfrq_sync #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_sync (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(byte_valid),
      .rx_byte   (req_item.rx_byte),
      .sync      (sync),
      .offset    (offset)
   );

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      req_stall  = !((state_ff == ST_IDLE) && out_free);
      accept     = req_valid && !req_stall;
      byte_valid = accept && (req_item.opcode == OP_BYTE);

      wnext = (wslot_ff == SLOT_W'(SLOTS - 1)) ? '0 : wslot_ff + SLOT_W'(1);
      rnext = (rslot_ff == SLOT_W'(SLOTS - 1)) ? '0 : rslot_ff + SLOT_W'(1);
      empty = (wslot_ff == rslot_ff);
      full  = (wnext == rslot_ff);

      waddr = ADDR_W'(wslot_ff) * ADDR_W'(PAY) + ADDR_W'(offset);
      raddr = rbase_ff + ADDR_W'(rd_cnt_ff);
      last  = (rd_cnt_ff == OFF_W'(PAY));

      state_in     = state_ff;
      wslot_in     = wslot_ff;
      rslot_in     = rslot_ff;
      rbase_in     = rbase_ff;
      rd_cnt_in    = rd_cnt_ff;
      inflight_in  = inflight_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.opcode == OP_TAKE) begin
                  if (empty) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{kind: KIND_EMPTY, payload_byte: 8'd0, last_of_run: 1'b1};
                  end else begin
                     state_in  = ST_TAKE;
                     rbase_in  = ADDR_W'(rslot_ff) * ADDR_W'(PAY);
                     rd_cnt_in = '0;
                  end
               end else if (sync.done) begin
                  if (full) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{kind: KIND_DROP, payload_byte: 8'd0, last_of_run: 1'b1};
                  end else begin
                     wslot_in = wnext;
                  end
               end
            end
         end
         ST_TAKE: begin
            if (inflight_ff) begin
               inflight_in  = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in       = '{kind: KIND_PAYLOAD, payload_byte: rdata_ff, last_of_run: last};
               if (last) begin
                  state_in = ST_IDLE;
                  rslot_in = rnext;
               end
            end else if (out_free) begin
               rd_en       = 1'b1;
               rd_cnt_in   = rd_cnt_ff + OFF_W'(1);
               inflight_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wslot_ff     <= '0;
         rslot_ff     <= '0;
         inflight_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wslot_ff     <= wslot_in;
         rslot_ff     <= rslot_in;
         inflight_ff  <= inflight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rbase_ff  <= rbase_in;
      rd_cnt_ff <= rd_cnt_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (sync.store) begin
         store_mem[waddr] <= req_item.rx_byte;
      end
      if (rd_en) begin
         rdata_ff <= store_mem[raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ tb/preamble_frame_receiver_queue_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for preamble_frame_receiver_queue: a behavioural deframer and
// message ring predicts every result, and a checker compares each transfer in order.
// Depends on pfrq_pkg and the preamble_frame_receiver_queue module only.
module preamble_frame_receiver_queue_tb;
   import pfrq_pkg::*;

   localparam int FRAME_BYTES   = 22;
   localparam int SLOTS         = 4;
   localparam int PAYLOAD_BYTES = FRAME_BYTES - PRE_LEN;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   pfrq_req_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   pfrq_rsp_type rsp_item;

   logic [7:0]   frame_bytes [FRAME_BYTES];
   int unsigned  frame_fill = 0;
   logic [7:0]   ring_store [SLOTS][PAYLOAD_BYTES];
   int unsigned  ring_head = 0;
   int unsigned  ring_tail = 0;
   pfrq_rsp_type due_results [$];

   int unsigned  failures = 0;
   int unsigned  n_bytes = 0;
   int unsigned  n_takes = 0;
   int unsigned  n_payload = 0;
   int unsigned  n_empty = 0;
   int unsigned  n_drop = 0;
   int unsigned  n_resync = 0;
   int unsigned  burst_left = 0;
   int unsigned  stall_span = 0;
   stall_mode_type stall_mode = STALL_NONE;

   preamble_frame_receiver_queue #(
      .FRAME_BYTES(FRAME_BYTES),
      .SLOTS(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic preamble_at(input int unsigned at);
      return frame_bytes[at] == PRE_A && frame_bytes[at + 1] == PRE_B &&
             frame_bytes[at + 2] == PRE_A && frame_bytes[at + 3] == PRE_B;
   endfunction

   function automatic int unsigned messages_held();
      return (ring_head + SLOTS - ring_tail) % SLOTS;
   endfunction

   function automatic void expect_result(input logic [1:0] kind, input logic [7:0] data,
                                         input logic last);
      pfrq_rsp_type r;
      r.kind = kind;
      r.payload_byte = data;
      r.last_of_run = last;
      due_results.push_back(r);
   endfunction

   task automatic track_receiver(input pfrq_req_type it);
      int unsigned i;
      if (it.opcode == OP_TAKE) begin
         n_takes++;
         if (messages_held() == 0) begin
            n_empty++;
            expect_result(KIND_EMPTY, 8'h00, 1'b1);
         end else begin
            n_payload += PAYLOAD_BYTES;
            for (i = 0; i < PAYLOAD_BYTES; i++) begin
               expect_result(KIND_PAYLOAD, ring_store[ring_tail][i], i == PAYLOAD_BYTES - 1);
            end
            ring_tail = (ring_tail + 1) % SLOTS;
         end
      end else begin
         n_bytes++;
         if (frame_fill >= FRAME_BYTES) frame_fill = 0;
         frame_bytes[frame_fill] = it.rx_byte;
         if (frame_fill == PRE_LEN - 1 && !preamble_at(0)) begin
            for (i = 0; i < PRE_LEN - 1; i++) frame_bytes[i] = frame_bytes[i + 1];
            frame_fill--;
         end
         if (frame_fill > PRE_LEN && preamble_at(frame_fill - PRE_LEN)) begin
            n_resync++;
            frame_bytes[0] = PRE_A;
            frame_bytes[1] = PRE_B;
            frame_bytes[2] = PRE_A;
            frame_bytes[3] = PRE_B;
            frame_bytes[PRE_LEN] = frame_bytes[frame_fill];
            frame_fill = PRE_LEN;
         end
         frame_fill++;
         if (frame_fill == FRAME_BYTES) begin
            frame_fill = 0;
            if (messages_held() >= SLOTS - 1) begin
               n_drop++;
               expect_result(KIND_DROP, 8'h00, 1'b1);
            end else begin
               for (i = 0; i < PAYLOAD_BYTES; i++) begin
                  ring_store[ring_head][i] = frame_bytes[PRE_LEN + i];
               end
               ring_head = (ring_head + 1) % SLOTS;
            end
         end
      end
   endtask

   task automatic offer_request(input logic op, input logic [7:0] data);
      pfrq_req_type it;
      int unsigned gap;
      it.opcode = op;
      it.rx_byte = data;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      track_receiver(it);
   endtask

   task automatic send_byte(input logic [7:0] b);
      offer_request(OP_BYTE, b);
   endtask

   task automatic send_take();
      offer_request(OP_TAKE, 8'($urandom));
   endtask

   task automatic send_preamble();
      send_byte(PRE_A);
      send_byte(PRE_B);
      send_byte(PRE_A);
      send_byte(PRE_B);
   endtask

   function automatic logic [7:0] stream_byte();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return PRE_A;
      if (pick == 1) return PRE_B;
      return 8'($urandom);
   endfunction

   // A resynchronising frame carries a second preamble early enough that the byte after it
   // still falls inside the frame.
   task automatic send_frame(input bit with_resync);
      int unsigned k, i;
      if (with_resync) begin
         send_preamble();
         k = $urandom_range(0, PAYLOAD_BYTES - 5);
         for (i = 0; i < k; i++) send_byte(stream_byte());
      end
      send_preamble();
      for (i = 0; i < PAYLOAD_BYTES; i++) send_byte(stream_byte());
   endtask

   task automatic test_empty_take();
      offer_request(OP_TAKE, 8'hFF);
   endtask

   task automatic test_sync_and_edges();
      logic [7:0] lead [7];
      logic [7:0] body [PAYLOAD_BYTES];
      int unsigned i;
      lead = '{8'h7F, 8'hFF, 8'h7F, 8'h7F, 8'hFF, 8'h7F, 8'hFF};
      body = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'hFE, 8'hAA, 8'h55, 8'h7F,
               8'hFF, 8'h7F, 8'h00, 8'hFF, 8'hFF, 8'h10, 8'h20, 8'hC3, 8'h3C};
      for (i = 0; i < 7; i++) send_byte(lead[i]);
      for (i = 0; i < PAYLOAD_BYTES; i++) send_byte(body[i]);
      offer_request(OP_TAKE, 8'h00);
   endtask

   task automatic test_ring_overflow();
      int unsigned n;
      for (n = 0; n < SLOTS; n++) begin
         if ($urandom_range(0, 1) == 1) send_byte(stream_byte());
         send_frame($urandom_range(0, 3) == 0);
      end
      for (n = 0; n < SLOTS; n++) send_take();
   endtask

   task automatic test_mixed_stream();
      int unsigned stop_at, pick;
      stop_at = n_bytes + n_takes + 30;
      while (n_bytes + n_takes < stop_at) begin
         pick = $urandom_range(0, 19);
         if (pick < 9) begin
            send_frame($urandom_range(0, 3) == 0);
         end else if (pick < 16) begin
            repeat ($urandom_range(1, 3)) send_take();
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(stream_byte());
         end
      end
   endtask

   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         stall_span = $urandom_range(16, 96);
      end
      stall_span--;
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 2) != 0);
      endcase
   end

   function automatic void report_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
      failures++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
   endfunction

   always @(posedge clock) begin : check_results
      pfrq_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (due_results.size() == 0) begin
            failures++;
            $display("%0t ns: unexpected transfer, expected none, got kind %0h byte %0h last %0h",
                     $time, rsp_item.kind, rsp_item.payload_byte, rsp_item.last_of_run);
         end else begin
            want = due_results.pop_front();
            if (rsp_item.kind !== want.kind) begin
               report_field("kind", want.kind, rsp_item.kind);
            end
            if (rsp_item.payload_byte !== want.payload_byte) begin
               report_field("payload_byte", want.payload_byte, rsp_item.payload_byte);
            end
            if (rsp_item.last_of_run !== want.last_of_run) begin
               report_field("last_of_run", want.last_of_run, rsp_item.last_of_run);
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_take();
      test_sync_and_edges();
      test_ring_overflow();
      test_mixed_stream();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d serial bytes and %0d takes, with %0d resynchronisations.",
               n_bytes, n_takes, n_resync);
      $display("Checked %0d payload bytes, %0d empty takes and %0d dropped frames.",
               n_payload, n_empty, n_drop);
      if (failures == 0) begin
         $display("PASS preamble_frame_receiver_queue");
      end else begin
         $display("FAIL preamble_frame_receiver_queue");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL preamble_frame_receiver_queue");
      $finish;
   end

endmodule

@@ filelist.f @@
src/pfrq_pkg.sv
src/pfrq_sync.sv
src/preamble_frame_receiver_queue.sv
tb/preamble_frame_receiver_queue_tb.sv
